[design/multilevel_feedback_queue_scheduler_defines.svh]
// assertion macros for the multilevel feedback queue scheduler
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define MFQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mfqs_pkg.sv]
// shared types, widths and codes for the multilevel feedback queue scheduler
package mfqs_pkg;

  localparam int MAX_LEVELS_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ID_W       = 8;
  localparam int WORK_W     = 12;
  localparam int STATUS_W   = 3;
  localparam int LEVEL_W    = 3;
  localparam int NUM_LVL_W  = 3;
  localparam int UNIT_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [NUM_LVL_W-1:0] NUM_LEVELS_RST   = 3'd3;
  localparam logic [UNIT_W-1:0]    QUANTUM_UNIT_RST = 8'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_DONE    = 3'd2,
    ST_DEMOTED = 3'd3,
    ST_IDLE    = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_LEVELS   = 2'd0,
    REG_QUANTUM_UNIT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    MODE_ADD      = 1'b0,
    MODE_DISPATCH = 1'b1
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]   task_id;
    logic [WORK_W-1:0] work;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [ID_W-1:0]     task_id;
    logic [LEVEL_W-1:0]  level;
    logic [WORK_W-1:0]   run_time;
    logic [WORK_W-1:0]   remaining;
    logic                idle;
  } res_t;

endpackage

[design/mfqs_store.sv]
// task entry memory, one ring of slots per level
module mfqs_store #(
  parameter int DEPTH = mfqs_pkg::MAX_LEVELS_DEF * mfqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output mfqs_pkg::entry_t         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  mfqs_pkg::entry_t         wr_data
);

  mfqs_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/mfqs_ctrl.sv]
// level bookkeeping, level selection and dispatch arithmetic
module mfqs_ctrl #(
  parameter int MAX_LEVELS  = mfqs_pkg::MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = mfqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [mfqs_pkg::NUM_LVL_W-1:0]          num_levels,
  input  logic [mfqs_pkg::UNIT_W-1:0]             quantum_unit,
  input  mfqs_pkg::mode_t                         mode,
  input  logic [mfqs_pkg::ID_W-1:0]               task_id,
  input  logic [mfqs_pkg::WORK_W-1:0]             work_amount,
  input  logic                                    exec,
  output logic [$clog2(MAX_LEVELS*QUEUE_DEPTH)-1:0] rd_addr,
  input  mfqs_pkg::entry_t                        rd_data,
  output logic                                    wr_en,
  output logic [$clog2(MAX_LEVELS*QUEUE_DEPTH)-1:0] wr_addr,
  output mfqs_pkg::entry_t                        wr_data,
  output mfqs_pkg::res_t                          res
);

  localparam int LW = $clog2(MAX_LEVELS);
  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(MAX_LEVELS * QUEUE_DEPTH);
  localparam int NW = $clog2(MAX_LEVELS + 1);
  localparam int QW = mfqs_pkg::UNIT_W + NW;
  localparam int XW = (QW > mfqs_pkg::WORK_W) ? QW : mfqs_pkg::WORK_W;

  logic [SW-1:0] head       [MAX_LEVELS];
  logic [SW-1:0] head_next  [MAX_LEVELS];
  logic [CW-1:0] count      [MAX_LEVELS];
  logic [CW-1:0] count_next [MAX_LEVELS];
  logic [CW-1:0] total;
  logic [CW-1:0] total_next;

  logic                        found;
  logic [LW-1:0]               sel;
  logic [LW-1:0]               nxt;
  logic [NW-1:0]               lim;
  logic [NW-1:0]               lvl_num;
  logic [QW-1:0]               quantum;
  logic [mfqs_pkg::WORK_W-1:0] left;
  logic [mfqs_pkg::WORK_W-1:0] charge;
  logic                        fits;
  logic                        last;

  function automatic logic [SW-1:0] ring_tail(input logic [SW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] sum;
    sum = (CW+1)'(h) + (CW+1)'(c);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[SW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [LW-1:0] l, input logic [SW-1:0] s);
    return AW'(l) * AW'(QUEUE_DEPTH) + AW'(s);
  endfunction

  // lowest-numbered non-empty level
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        sel   = LW'(i);
      end
    end
  end

  always_comb begin
    if (num_levels == '0) begin
      lim = NW'(1);
    end else if (int'(num_levels) > MAX_LEVELS) begin
      lim = NW'(MAX_LEVELS);
    end else begin
      lim = NW'(num_levels);
    end
  end

  assign nxt     = (sel == LW'(MAX_LEVELS - 1)) ? sel : sel + LW'(1);
  assign lvl_num = NW'(sel) + NW'(1);
  assign quantum = QW'(lvl_num) * QW'(quantum_unit);
  assign left    = rd_data.work;
  assign charge  = mfqs_pkg::WORK_W'(quantum);
  assign fits    = XW'(left) <= XW'(quantum);
  assign last    = lvl_num >= lim;
  assign rd_addr = slot_addr(sel, head[sel]);

  always_comb begin
    head_next  = head;
    count_next = count;
    total_next = total;
    wr_en      = 1'b0;
    wr_addr    = slot_addr('0, ring_tail(head[0], count[0]));
    wr_data    = '{task_id: task_id, work: work_amount};
    res        = '0;
    res.status = mfqs_pkg::ST_IDLE;
    if (exec) begin
      if (mode == mfqs_pkg::MODE_ADD) begin
        res.task_id = task_id;
        if (total >= CW'(QUEUE_DEPTH)) begin
          res.status = mfqs_pkg::ST_FULL;
        end else begin
          wr_en         = 1'b1;
          count_next[0] = count[0] + CW'(1);
          total_next    = total + CW'(1);
          res.status    = mfqs_pkg::ST_ADDED;
          res.level     = mfqs_pkg::LEVEL_W'(1);
          res.remaining = work_amount;
        end
      end else if (found) begin
        head_next[sel]  = (head[sel] == SW'(QUEUE_DEPTH - 1)) ? '0 : head[sel] + SW'(1);
        count_next[sel] = count[sel] - CW'(1);
        total_next      = total - CW'(1);
        res.task_id     = rd_data.task_id;
        res.level       = mfqs_pkg::LEVEL_W'(lvl_num);
        if (fits || last) begin
          res.status   = mfqs_pkg::ST_DONE;
          res.run_time = left;
        end else begin
          res.status      = mfqs_pkg::ST_DEMOTED;
          res.run_time    = charge;
          res.remaining   = left - charge;
          wr_en           = 1'b1;
          wr_addr         = slot_addr(nxt, ring_tail(head[nxt], count[nxt]));
          wr_data         = '{task_id: rd_data.task_id, work: left - charge};
          count_next[nxt] = count[nxt] + CW'(1);
          total_next      = total;
        end
      end
    end
    res.idle = (total_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
      end
      total <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      total <= total_next;
    end
  end

endmodule

[design/multilevel_feedback_queue_scheduler.sv]
// top level of the multilevel feedback queue scheduler
//
// s_* carries add and dispatch requests: s_tuser is the mode (add or
// dispatch), s_tdata the task id and work amount. m_* returns one result
// per request: m_tuser is the status code, m_tdata the task id, level,
// run time, remaining work and the idle flag. cfg_* writes num_levels
// (index 0) and quantum_unit (index 1); it is always ready. It is to be
// written only while no request is in flight; the block does not enforce it.
// A request is accepted at one edge; at that edge the head entry of the
// lowest non-empty level is read from the entry memory. Once the result
// register is free, the entry is updated and written back to its new
// level and the result register loads. The registered read of the entry
// memory comes ahead of the write-back; s_tready is low while a request
// is in flight, until the result register loads.
// When the receiver stalls, the result holds in the output register; the
// next request is still accepted and finishes once that register frees up.
// Reset empties all levels and restores num_levels 3 and quantum_unit 10;
// the entry memory itself is not cleared.
`include "multilevel_feedback_queue_scheduler_defines.svh"

module multilevel_feedback_queue_scheduler #(
  parameter int MAX_LEVELS  = mfqs_pkg::MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = mfqs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mfqs_pkg::IN_DATA_W-1:0]  s_tdata,   // task_id, work_amount, zero pad
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mfqs_pkg::OUT_DATA_W-1:0] m_tdata,   // task_id_res, level, run_time,
                                                     // remaining, idle, zero pad
  output logic [mfqs_pkg::STATUS_W-1:0]   m_tuser,   // status
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mfqs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfqs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(MAX_LEVELS * QUEUE_DEPTH);
  localparam int PAD_W = mfqs_pkg::OUT_DATA_W - $bits(mfqs_pkg::res_t) + mfqs_pkg::STATUS_W;

  logic                          busy;
  mfqs_pkg::mode_t               mode;
  logic [mfqs_pkg::ID_W-1:0]     task_id;
  logic [mfqs_pkg::WORK_W-1:0]   work_amount;
  logic [mfqs_pkg::NUM_LVL_W-1:0] num_levels;
  logic [mfqs_pkg::UNIT_W-1:0]   quantum_unit;
  logic                          accept;
  logic                          exec;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          wr_en;
  mfqs_pkg::entry_t              rd_data;
  mfqs_pkg::entry_t              wr_data;
  mfqs_pkg::res_t                res;
  mfqs_pkg::res_t                res_q;

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign exec      = busy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels   <= mfqs_pkg::NUM_LEVELS_RST;
      quantum_unit <= mfqs_pkg::QUANTUM_UNIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mfqs_pkg::REG_NUM_LEVELS:   num_levels   <= cfg_data[mfqs_pkg::NUM_LVL_W-1:0];
        mfqs_pkg::REG_QUANTUM_UNIT: quantum_unit <= cfg_data[mfqs_pkg::UNIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      mode        <= mfqs_pkg::mode_t'(s_tuser);
      task_id     <= s_tdata[mfqs_pkg::ID_W-1:0];
      work_amount <= s_tdata[mfqs_pkg::ID_W +: mfqs_pkg::WORK_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (exec) begin
      busy <= 1'b0;
    end
  end

  mfqs_store #(
    .DEPTH (MAX_LEVELS * QUEUE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mfqs_ctrl #(
    .MAX_LEVELS  (MAX_LEVELS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .num_levels   (num_levels),
    .quantum_unit (quantum_unit),
    .mode         (mode),
    .task_id      (task_id),
    .work_amount  (work_amount),
    .exec         (exec),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      res_q <= res;
    end
  end

  assign m_tuser = res_q.status;
  assign m_tdata = {PAD_W'(0), res_q.idle, res_q.remaining, res_q.run_time,
                    res_q.level, res_q.task_id};

  `MFQS_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && !s_tready,
                    "accepted transaction not in flight")
  `MFQS_ASSERT_NEXT(a_exec_result, clk, rst, exec, m_tvalid && !busy,
                    "executed transaction gave no result")
  `MFQS_ASSERT_NOW(a_idle_result, clk, rst,
                   m_tvalid && (res_q.status == mfqs_pkg::ST_IDLE),
                   res_q.idle && (res_q.task_id == '0),
                   "idle result with queued task")

endmodule

[sim/tb_multilevel_feedback_queue_scheduler.sv]
// self-checking testbench for the multilevel feedback queue scheduler
`timescale 1ns / 100ps

module tb_multilevel_feedback_queue_scheduler;

  localparam int LEVELS = mfqs_pkg::MAX_LEVELS_DEF;
  localparam int DEPTH  = mfqs_pkg::QUEUE_DEPTH_DEF;
  localparam logic [mfqs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [mfqs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct {
    mfqs_pkg::mode_t             mode;
    logic [mfqs_pkg::ID_W-1:0]   id;
    logic [mfqs_pkg::WORK_W-1:0] work;
  } sched_req_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mfqs_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // task_id, work_amount, zero pad
  logic                            s_tuser = 1'b0; // mode
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mfqs_pkg::OUT_DATA_W-1:0] m_tdata;        // task_id_res, level, run_time,
                                                   // remaining, idle, zero pad
  logic [mfqs_pkg::STATUS_W-1:0]   m_tuser;        // status
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mfqs_pkg::CFG_IDX_W-1:0]  cfg_index = mfqs_pkg::REG_NUM_LEVELS;
  logic [mfqs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multilevel_feedback_queue_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // scheduler state as predicted
  logic [mfqs_pkg::NUM_LVL_W-1:0] sched_levels = mfqs_pkg::NUM_LEVELS_RST;
  logic [mfqs_pkg::UNIT_W-1:0]    sched_unit   = mfqs_pkg::QUANTUM_UNIT_RST;
  mfqs_pkg::entry_t               level_fifo[LEVELS][$];
  int                             queued_tasks = 0;

  sched_req_t     req_q[$];
  mfqs_pkg::res_t result_q[$];
  sched_req_t     cur_req;
  int             src_gap = 0;
  int             sink_stall = 0;
  bit             src_steady = 1'b0;
  bit             sink_steady = 1'b0;
  int             err_count = 0;
  int             n_added = 0, n_full = 0, n_done = 0, n_demoted = 0, n_idle = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic mfqs_pkg::res_t schedule_step(sched_req_t req);
    mfqs_pkg::res_t   r;
    int               q;
    int               lim;
    int               quantum;
    mfqs_pkg::entry_t e;
    r = '0;
    if (req.mode == mfqs_pkg::MODE_ADD) begin
      r.task_id = req.id;
      if (queued_tasks >= DEPTH) begin
        r.status = mfqs_pkg::ST_FULL;
      end else begin
        e.task_id = req.id;
        e.work = req.work;
        level_fifo[0] = {level_fifo[0], e};
        queued_tasks++;
        r.status = mfqs_pkg::ST_ADDED;
        r.level = mfqs_pkg::LEVEL_W'(1);
        r.remaining = req.work;
      end
    end else begin
      q = -1;
      for (int i = LEVELS - 1; i >= 0; i--)
        if (level_fifo[i].size() != 0) q = i;
      if (q < 0) begin
        r.status = mfqs_pkg::ST_IDLE;
      end else begin
        lim = (sched_levels < 1) ? 1 : (sched_levels > LEVELS) ? LEVELS : int'(sched_levels);
        e = level_fifo[q].pop_front();
        queued_tasks--;
        quantum = (q + 1) * int'(sched_unit);
        r.task_id = e.task_id;
        r.level = mfqs_pkg::LEVEL_W'(q + 1);
        if (int'(e.work) <= quantum || q + 1 >= lim) begin
          r.status = mfqs_pkg::ST_DONE;
          r.run_time = e.work;
        end else begin
          r.status = mfqs_pkg::ST_DEMOTED;
          r.run_time = mfqs_pkg::WORK_W'(quantum);
          r.remaining = e.work - mfqs_pkg::WORK_W'(quantum);
          e.work = r.remaining;
          level_fifo[q + 1] = {level_fifo[q + 1], e};
          queued_tasks++;
        end
      end
    end
    r.idle = (queued_tasks == 0);
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        result_q = {result_q, schedule_step(cur_req)};
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (req_q.size() != 0) begin
          cur_req = req_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_req.mode;
          s_tdata <= {4'b0, cur_req.work, cur_req.id};
          src_gap = src_steady ? 0 : $urandom_range(0, 15);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    mfqs_pkg::res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transaction, status", int'(m_tuser), -1);
        end else begin
          want = result_q.pop_front();
          if (m_tuser != want.status)
            report_mismatch("status", int'(m_tuser), int'(want.status));
          if (m_tdata[7:0] != want.task_id)
            report_mismatch("task_id", int'(m_tdata[7:0]), int'(want.task_id));
          if (m_tdata[10:8] != want.level)
            report_mismatch("level", int'(m_tdata[10:8]), int'(want.level));
          if (m_tdata[22:11] != want.run_time)
            report_mismatch("run_time", int'(m_tdata[22:11]), int'(want.run_time));
          if (m_tdata[34:23] != want.remaining)
            report_mismatch("remaining", int'(m_tdata[34:23]), int'(want.remaining));
          if (m_tdata[35] != want.idle)
            report_mismatch("idle", int'(m_tdata[35]), int'(want.idle));
          case (want.status)
            mfqs_pkg::ST_ADDED:   n_added++;
            mfqs_pkg::ST_FULL:    n_full++;
            mfqs_pkg::ST_DONE:    n_done++;
            mfqs_pkg::ST_DEMOTED: n_demoted++;
            default:              n_idle++;
          endcase
        end
        sink_stall = sink_steady ? 0 : $urandom_range(0, 15);
      end else if (sink_stall > 0) begin
        sink_stall--;
      end
      m_tready <= (sink_stall == 0);
    end
  end

  task automatic queue_req(mfqs_pkg::mode_t mode, int id, int work);
    sched_req_t r;
    r.mode = mode;
    r.id = mfqs_pkg::ID_W'(id);
    r.work = mfqs_pkg::WORK_W'(work);
    req_q = {req_q, r};
  endtask

  task automatic write_reg(logic [mfqs_pkg::CFG_IDX_W-1:0] idx,
                           logic [mfqs_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == mfqs_pkg::REG_NUM_LEVELS) sched_levels = val[mfqs_pkg::NUM_LVL_W-1:0];
    else if (idx == mfqs_pkg::REG_QUANTUM_UNIT) sched_unit = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (req_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    int left;
    int burst;
    int add_pct;
    int sel;
    int work;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(4, 24);
      sel = $urandom_range(0, 2);
      add_pct = (sel == 0) ? 85 : (sel == 1) ? 50 : 15;
      for (int i = 0; i < burst && left > 0; i++, left--) begin
        sel = $urandom_range(0, 3);
        work = (sel == 0) ? $urandom_range(0, 15) :
               (sel == 1) ? $urandom_range(0, 255) : $urandom_range(0, 4095);
        queue_req(($urandom_range(0, 99) < add_pct) ? mfqs_pkg::MODE_ADD
                                                    : mfqs_pkg::MODE_DISPATCH,
                  $urandom_range(0, 255), work);
      end
    end
  endtask

  initial begin
    int lvl_plan[10] = '{1, 4, 0, 7, 2, 3, 4, 5, 1, 4};
    int unit_plan[10] = '{255, 1, 0, 37, 3, 255, 1, 0, 8, 200};
    logic [mfqs_pkg::CFG_DATA_W-1:0] lvl_word;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty dispatch, zero and full-scale work, id extremes, fill past capacity, then dispatches
    queue_req(mfqs_pkg::MODE_DISPATCH, 0, 0);
    queue_req(mfqs_pkg::MODE_ADD, 8'h00, 0);
    queue_req(mfqs_pkg::MODE_ADD, 8'hFF, 12'hFFF);
    queue_req(mfqs_pkg::MODE_ADD, 8'hA5, 1);
    queue_req(mfqs_pkg::MODE_ADD, 8'h5A, 30);
    for (int i = 0; i < 13; i++)
      queue_req(mfqs_pkg::MODE_ADD, 8'h10 + i, (i * 331) % 4096);
    repeat (7)
      queue_req(mfqs_pkg::MODE_DISPATCH, $urandom_range(0, 255), $urandom_range(0, 4095));

    for (int ph = 0; ph < 10; ph++) begin
      wait_for_drain();
      if (ph == 0) begin
        write_reg(REG_SPARE_LO, mfqs_pkg::CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_SPARE_HI, mfqs_pkg::CFG_DATA_W'($urandom_range(0, 255)));
      end
      lvl_word = mfqs_pkg::CFG_DATA_W'($urandom_range(0, 255));
      lvl_word[mfqs_pkg::NUM_LVL_W-1:0] = mfqs_pkg::NUM_LVL_W'(lvl_plan[ph]);
      write_reg(mfqs_pkg::REG_NUM_LEVELS, lvl_word);
      write_reg(mfqs_pkg::REG_QUANTUM_UNIT, mfqs_pkg::CFG_DATA_W'(unit_plan[ph]));
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      queue_random(80);
    end
    wait_for_drain();
    repeat (10) @(posedge clk);

    if (result_q.size() != 0) report_mismatch("results never seen", 0, result_q.size());
    $display("covered %0d adds (%0d refused) and %0d dispatches across 10 register settings",
             n_added + n_full, n_full, n_done + n_demoted + n_idle);
    $display("dispatch outcomes: %0d completed, %0d demoted, %0d idle",
             n_done, n_demoted, n_idle);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/mfqs_pkg.sv
design/mfqs_store.sv
design/mfqs_ctrl.sv
design/multilevel_feedback_queue_scheduler.sv
sim/tb_multilevel_feedback_queue_scheduler.sv
